// ===== hdl/pidpi_pkg.sv =====
// pidpi_pkg: widths, register map and shared types of the pid controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pidpi_pkg;

  localparam int MEAS_W  = 16;            // measurement width
  localparam int TGT_W   = 16;            // setpoint width
  localparam int GAIN_W  = 24;            // signed q8.16 gain
  localparam int FRAC_W  = 16;            // fraction bits of the gains
  localparam int ERR_W   = MEAS_W + 1;    // target - measurement
  localparam int DIFF_W  = ERR_W + 1;     // e - last
  localparam int DD_W    = ERR_W + 2;     // e - 2*last + prev
  localparam int SUM_W   = 32;            // saturating error sum
  localparam int PROD_W  = GAIN_W + SUM_W;
  localparam int ACC_W   = PROD_W + 2;    // three products plus setpoint
  localparam int WHOLE_W = ACC_W - FRAC_W;
  localparam int OUT_W   = 32;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int ADDR_W  = 5;
  localparam int IDX_LSB = 2;
  localparam int DATA_W  = 32;

  typedef enum logic [ADDR_W-IDX_LSB-1:0] {
    REG_TARGET     = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_INCR_MODE  = 3'd4,
    REG_ADD_TARGET = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [TGT_W-1:0]  target;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic                     incr_mode;
    logic                     add_target;
  } cfg_t;

  // terms of one control step, ready for the multiply engine
  typedef struct packed {
    logic signed [DIFF_W-1:0] tp;
    logic signed [SUM_W-1:0]  ti;
    logic signed [DD_W-1:0]   td;
  } work_t;

  typedef struct packed {
    logic busy;
    logic fin_valid;
    logic fin_hold;
  } back_stat_t;

endpackage

// ===== hdl/pidpi_front.sv =====
// pidpi_front: accepts measurements, forms the error, keeps the error history
// and sum, and pushes the three control terms into the queue; uses pidpi_pkg
`timescale 1ns / 1ps

module pidpi_front import pidpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [MEAS_W-1:0] measurement,
  input  logic                     q_full,
  output logic                     q_push,
  output work_t                    q_wdata
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  last_error;
  logic signed [ERR_W-1:0]  error_before_last;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [SUM_W-1:0]  error_sum_next;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [DIFF_W-1:0] diff1;
  logic signed [DD_W-1:0]   diff2;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    err      = ERR_W'(cfg.target) - ERR_W'(measurement);
    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      error_sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_next = sum_wide[SUM_W-1:0];
    end
    diff1 = DIFF_W'(err) - DIFF_W'(last_error);
    diff2 = DD_W'(err) - (DD_W'(last_error) <<< 1) + DD_W'(error_before_last);
    if (cfg.incr_mode) begin
      q_wdata.tp = diff1;
      q_wdata.ti = SUM_W'(err);
      q_wdata.td = diff2;
    end else begin
      q_wdata.tp = DIFF_W'(err);
      q_wdata.ti = error_sum_next;
      q_wdata.td = DD_W'(diff1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum         <= '0;
      last_error        <= '0;
      error_before_last <= '0;
    end else if (q_push) begin
      error_sum         <= error_sum_next;
      error_before_last <= last_error;
      last_error        <= err;
    end
  end

endmodule

// ===== hdl/pidpi_queue.sv =====
// pidpi_queue: short fifo of control terms between front and back
// uses pidpi_pkg for the entry type and depth
`timescale 1ns / 1ps

module pidpi_queue import pidpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  work_t             wdata,
  output logic              full,
  input  logic              pop,
  output work_t             rdata,
  output logic              valid,
  output logic [QCNT_W-1:0] count
);

  work_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== hdl/pidpi_back.sv =====
// pidpi_back: shared multiplier stepping through the three gain products,
// then truncation toward zero, saturation and the output register; uses pidpi_pkg
`timescale 1ns / 1ps

module pidpi_back import pidpi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    q_valid,
  input  work_t                   q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] drive,
  output back_stat_t              stat
);

  typedef enum logic [1:0] {
    ST_P,
    ST_I,
    ST_D,
    ST_ADD
  } step_t;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  step_t                      step;
  logic                       busy;
  work_t                      cur;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    base;
  logic signed [ACC_W-1:0]    fin;
  logic                       fin_valid;
  logic signed [GAIN_W-1:0]   gain_sel;
  logic signed [SUM_W-1:0]    term_sel;
  logic signed [WHOLE_W-1:0]  whole;
  logic signed [WHOLE_W-1:0]  whole_rnd;
  logic signed [OUT_W-1:0]    drive_next;
  logic                       out_free;
  logic                       fin_free;
  logic                       advance;
  logic                       load;

  assign out_free = !out_valid || !out_stall;
  assign fin_free = !fin_valid || out_free;
  assign advance  = busy && ((step != ST_ADD) || fin_free);
  assign load     = q_valid && (!busy || ((step == ST_ADD) && fin_free));
  assign q_pop    = load;

  assign stat.busy      = busy;
  assign stat.fin_valid = fin_valid;
  assign stat.fin_hold  = fin_valid && !out_free;

  always_comb begin
    case (step)
      ST_P: begin
        gain_sel = cfg.gain_p;
        term_sel = SUM_W'(cur.tp);
      end
      ST_I: begin
        gain_sel = cfg.gain_i;
        term_sel = cur.ti;
      end
      ST_D: begin
        gain_sel = cfg.gain_d;
        term_sel = SUM_W'(cur.td);
      end
      default: begin
        gain_sel = '0;
        term_sel = '0;
      end
    endcase
    prod_next = gain_sel * term_sel;
    base      = cfg.add_target ? (ACC_W'(cfg.target) <<< FRAC_W) : '0;
  end

  // truncate toward zero: bump the floor when negative with a fraction left
  always_comb begin
    whole     = WHOLE_W'(fin >>> FRAC_W);
    whole_rnd = whole + WHOLE_W'(fin[ACC_W-1] && (fin[FRAC_W-1:0] != '0));
    if ((&whole_rnd[WHOLE_W-1:OUT_W-1]) || !(|whole_rnd[WHOLE_W-1:OUT_W-1])) begin
      drive_next = whole_rnd[OUT_W-1:0];
    end else begin
      drive_next = whole_rnd[WHOLE_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= ST_P;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        case (step)
          ST_P: begin
            prod <= prod_next;
            step <= ST_I;
          end
          ST_I: begin
            prod <= prod_next;
            acc  <= base + ACC_W'(prod);
            step <= ST_D;
          end
          ST_D: begin
            prod <= prod_next;
            acc  <= acc + ACC_W'(prod);
            step <= ST_ADD;
          end
          ST_ADD: begin
            fin  <= acc + ACC_W'(prod);
            busy <= 1'b0;
            step <= ST_P;
          end
          default: begin
            step <= ST_P;
          end
        endcase
      end
      if (load) begin
        cur  <= q_rdata;
        busy <= 1'b1;
        step <= ST_P;
      end

      if (fin_valid && out_free) begin
        fin_valid <= 1'b0;
      end
      if (advance && (step == ST_ADD)) begin
        fin_valid <= 1'b1;
      end

      if (fin_valid && out_free) begin
        out_valid <= 1'b1;
        drive     <= drive_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/pid_controller_pos_incr.sv =====
// pid_controller_pos_incr: top level with the apb register file, front,
// term queue and multiply back end; uses pidpi_pkg and the pidpi_* modules
//
//   channel   direction  signals                           transaction when
//   input     in         in_valid, in_stall, measurement   in_valid && !in_stall
//   output    out        out_valid, out_stall, drive       out_valid && !out_stall
//   config    in/out     psel, penable, pwrite, paddr,     psel && penable &&
//                        pwdata, prdata, pready            pwrite && pready
//
// the front takes one measurement a cycle while the two-entry queue has room
// the back end shares one 24x32 multiplier over three products in steps ST_P,
// ST_I and ST_D, adds in step ST_ADD and may load the next entry during ST_ADD;
// a sample goes through queue, these steps, finish and output registers to drive
// synchronous reset clears error history, sum, queue and valids; registers
// return to zero with add_target set
// a stalled output holds drive; one more result waits in the finish stage
`timescale 1ns / 1ps

module pid_controller_pos_incr import pidpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [MEAS_W-1:0] measurement,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  drive,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  cfg_t              cfg;
  reg_idx_t          reg_idx;
  logic              wr_en;
  logic              q_push;
  logic              q_full;
  work_t             q_wdata;
  logic              q_pop;
  logic              q_valid;
  work_t             q_rdata;
  logic [QCNT_W-1:0] q_count;
  back_stat_t        bstat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:IDX_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target     <= '0;
      cfg.gain_p     <= '0;
      cfg.gain_i     <= '0;
      cfg.gain_d     <= '0;
      cfg.incr_mode  <= 1'b0;
      cfg.add_target <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET:     cfg.target     <= pwdata[TGT_W-1:0];
        REG_GAIN_P:     cfg.gain_p     <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:     cfg.gain_i     <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:     cfg.gain_d     <= pwdata[GAIN_W-1:0];
        REG_INCR_MODE:  cfg.incr_mode  <= pwdata[0];
        REG_ADD_TARGET: cfg.add_target <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TARGET:     prdata = DATA_W'(cfg.target);
      REG_GAIN_P:     prdata = DATA_W'(cfg.gain_p);
      REG_GAIN_I:     prdata = DATA_W'(cfg.gain_i);
      REG_GAIN_D:     prdata = DATA_W'(cfg.gain_d);
      REG_INCR_MODE:  prdata = DATA_W'(cfg.incr_mode);
      REG_ADD_TARGET: prdata = DATA_W'(cfg.add_target);
      default:        prdata = '0;
    endcase
  end

  pidpi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .measurement (measurement),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  pidpi_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .count (q_count)
  );

  pidpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .stat      (bstat)
  );

`ifndef SYNTHESIS
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("term queue popped while empty");

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("term queue count beyond depth");

  a_fin_held : assert property (@(posedge clk) disable iff (rst)
    bstat.fin_hold |=> bstat.fin_valid)
    else $error("finished result lost while output stalled");

  a_busy_after_pop : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> bstat.busy)
    else $error("back end idle after taking a queue entry");
`endif

endmodule
